// ----- sv/tccs_pkg.sv -----
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared constants and types for the text console cursor and scroll block.
// ----------------------------------------------------------------------------
package tccs_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int WORD_W = 16;

  localparam logic [1:0] FUNC_PUT  = 2'd0;
  localparam logic [1:0] FUNC_BS   = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [COL_W:0] TAB_EXTRA = (COL_W + 1)'(5);

  localparam logic [WORD_W-1:0] RESET_CELL = 16'h0720;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic              vld;
    logic [WORD_W-1:0] cell_word;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              scrolled;
  } result_t;

endpackage

// ----- sv/text_console_cursor_scroll.sv -----
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// 80x25 text console with cursor, backspace, cell read-back and scrolling.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result is
// shown on the out_ ports for one cycle with out_strobe, and the receiver must
// take it then. Put, backspace and unused codes are handled in S_IDLE, the
// result appearing on the cycle after acceptance, so such transactions can
// follow each other every cycle unless a put scrolls. A read needs the single
// registered read port of the cell store and keeps busy high through S_READ,
// its result passing the store's read register and the output register. A put
// that scrolls also keeps busy high in S_FILL while the store's write port
// blanks the new bottom row; its own result is delivered at once. After reset
// busy stays high while the store is filled with grey spaces; configuration
// writes are taken at any time.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_func,
  input  logic [7:0]                    in_char_code,
  input  logic [tccs_pkg::ADDR_W-1:0]   in_cell_index,
  output logic                          out_strobe,
  output logic [tccs_pkg::WORD_W-1:0]   out_cell_word,
  output logic [tccs_pkg::COL_W-1:0]    out_cursor_column,
  output logic [tccs_pkg::ROW_W-1:0]    out_cursor_row,
  output logic                          out_scrolled,
  input  logic                          cfg_wr_en,
  input  logic [7:0]                    cfg_wr_data
);
  import tccs_pkg::*;

  ram_req_t          req;
  result_t           res;
  logic [WORD_W-1:0] rdata;
  logic [7:0]        text_color_r;
  logic              strobe_r;
  logic [WORD_W-1:0] cell_word_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic              scrolled_r;

  tccs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .func       (in_func),
    .char_code  (in_char_code),
    .cell_index (in_cell_index),
    .text_color (text_color_r),
    .rdata      (rdata),
    .busy       (busy),
    .req        (req),
    .res        (res)
  );

  tccs_cell_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= 8'd7;
      strobe_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        text_color_r <= cfg_wr_data;
      end
      strobe_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      cell_word_r <= res.cell_word;
      col_r       <= res.col;
      row_r       <= res.row;
      scrolled_r  <= res.scrolled;
    end
  end

  assign out_strobe        = strobe_r;
  assign out_cell_word     = cell_word_r;
  assign out_cursor_column = col_r;
  assign out_cursor_row    = row_r;
  assign out_scrolled      = scrolled_r;

endmodule

// ----- sv/tccs_cell_ram.sv -----
// ----------------------------------------------------------------------------
// tccs_cell_ram
// Text cell store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tccs_cell_ram (
  input  logic                             clk,
  input  tccs_pkg::ram_req_t               req,
  output logic [tccs_pkg::WORD_W-1:0]      rdata
);
  import tccs_pkg::*;

  logic [WORD_W-1:0] mem [CELL_COUNT];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/tccs_ctrl.sv -----
// ----------------------------------------------------------------------------
// tccs_ctrl
// Cursor, scroll offset and sequencer: decodes each transaction, drives the
// cell store and produces the result.
// ----------------------------------------------------------------------------
module tccs_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [1:0]                    func,
  input  logic [7:0]                    char_code,
  input  logic [tccs_pkg::ADDR_W-1:0]   cell_index,
  input  logic [7:0]                    text_color,
  input  logic [tccs_pkg::WORD_W-1:0]   rdata,
  output logic                          busy,
  output tccs_pkg::ram_req_t            req,
  output tccs_pkg::result_t             res
);
  import tccs_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_FILL  = 4'b1000
  } state_t;

  localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(SCREEN_COLUMNS);
  localparam logic [ADDR_W:0]   CELLS_A  = (ADDR_W + 1)'(CELL_COUNT);
  localparam logic [COL_W:0]    COLS_C   = (COL_W + 1)'(SCREEN_COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL = COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(SCREEN_ROWS - 1);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [ADDR_W-1:0] fill_base_r, fill_base_nxt;
  logic              rng_r, rng_nxt;

  logic [COL_W:0]    col_inc;
  logic [COL_W:0]    tab_col;
  logic              is_nl, is_tab, put_wrap, put_scroll;
  logic [COL_W-1:0]  put_col, bs_col;
  logic [ROW_W-1:0]  put_row, bs_row;
  logic [7:0]        shown;

  // The screen is a ring of rows: base_r is the physical start of logical
  // row zero, so a scroll only moves the base and clears one row.
  function automatic logic [ADDR_W-1:0] ring_addr(input logic [ADDR_W-1:0] lin,
                                                  input logic [ADDR_W-1:0] base);
    logic [ADDR_W:0] sum;
    sum = {1'b0, lin} + {1'b0, base};
    if (sum >= CELLS_A) begin
      sum = sum - CELLS_A;
    end
    return sum[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] lin_addr(input logic [COL_W-1:0] col,
                                                 input logic [ROW_W-1:0] row);
    logic [ADDR_W-1:0] prod;
    prod = ADDR_W'(ADDR_W'(row) * COLS_A);
    return prod + ADDR_W'(col);
  endfunction

  always_comb begin
    is_nl   = (char_code == CH_NEWLINE);
    is_tab  = (char_code == CH_TAB);
    shown   = (is_nl || is_tab) ? CH_SPACE : char_code;
    col_inc = {1'b0, col_r} + (COL_W + 1)'(1);
    tab_col = col_inc + TAB_EXTRA;
    put_wrap = is_nl || (col_inc >= COLS_C) || (is_tab && (tab_col >= COLS_C));
    put_scroll = put_wrap && (row_r == LAST_ROW);
    if (put_wrap) begin
      put_col = '0;
      put_row = put_scroll ? row_r : row_r + ROW_W'(1);
    end else begin
      put_col = is_tab ? tab_col[COL_W-1:0] : col_inc[COL_W-1:0];
      put_row = row_r;
    end

    bs_col = col_r;
    bs_row = row_r;
    if (col_r != '0) begin
      bs_col = col_r - COL_W'(1);
    end else if (row_r != '0) begin
      bs_row = row_r - ROW_W'(1);
      bs_col = LAST_COL;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    fill_base_nxt = fill_base_r;
    rng_nxt       = rng_r;
    req           = '0;
    res           = '0;
    res.col       = col_r;
    res.row       = row_r;

    unique case (state_r)
      S_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = cnt_r;
        req.wdata = RESET_CELL;
        if (cnt_r == ADDR_W'(CELL_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (func)
            FUNC_PUT: begin
              req.we       = 1'b1;
              req.waddr    = ring_addr(lin_addr(col_r, row_r), base_r);
              req.wdata    = {text_color, shown};
              col_nxt      = put_col;
              row_nxt      = put_row;
              res.vld      = 1'b1;
              res.col      = put_col;
              res.row      = put_row;
              res.scrolled = put_scroll;
              if (put_scroll) begin
                fill_base_nxt = base_r;
                base_nxt      = ring_addr(COLS_A, base_r);
                cnt_nxt       = '0;
                state_nxt     = S_FILL;
              end
            end
            FUNC_BS: begin
              req.we    = 1'b1;
              req.waddr = ring_addr(lin_addr(bs_col, bs_row), base_r);
              req.wdata = {text_color, CH_SPACE};
              col_nxt   = bs_col;
              row_nxt   = bs_row;
              res.vld   = 1'b1;
              res.col   = bs_col;
              res.row   = bs_row;
            end
            FUNC_READ: begin
              req.re    = 1'b1;
              req.raddr = ring_addr(cell_index, base_r);
              rng_nxt   = ({1'b0, cell_index} < CELLS_A);
              state_nxt = S_READ;
            end
            default: begin
              res.vld = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        res.vld       = 1'b1;
        res.cell_word = rng_r ? rdata : '0;
        state_nxt     = S_IDLE;
      end
      S_FILL: begin
        // The row that left the top comes back as the blank bottom row.
        req.we    = 1'b1;
        req.waddr = fill_base_r + cnt_r;
        req.wdata = '0;
        if (cnt_r == COLS_A - ADDR_W'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
      base_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      base_r  <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_base_r <= fill_base_nxt;
    rng_r       <= rng_nxt;
  end

endmodule
